@@ hw/rtl/lfsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsl_pkg
// Shared types, register indexes, reset values and the microprogram of the
// line follower steering law.
// ----------------------------------------------------------------------------
package lfsl_pkg;

  // Field widths fixed by the interface
  localparam int POS_W    = 16;
  localparam int OUT_W    = 12;
  localparam int CURVE_W  = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic signed [OUT_W-1:0] SAT_MAX = 12'sd2047;
  localparam logic signed [OUT_W-1:0] SAT_MIN = -12'sd2048;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_START      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_CURVE_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LINE_ERROR  = 3'd6;

  // Register reset values
  localparam logic [6:0]  RST_BASE_SPEED       = 7'd35;
  localparam logic [7:0]  RST_CURVE_GAIN       = 8'd110;
  localparam logic [12:0] RST_CURVE_START      = 13'd2376;
  localparam logic [12:0] RST_SLOWDOWN_GAIN    = 13'd3277;
  localparam logic [7:0]  RST_STEER_GAIN       = 8'd12;
  localparam logic [7:0]  RST_STEER_CURVE_GAIN = 8'd60;
  localparam logic [14:0] RST_LOST_LINE_ERROR  = 15'd8192;

  // Input and result beats
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    position_valid;
    logic                    restart;
  } lfsl_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_power;
    logic signed [OUT_W-1:0] right_power;
    logic signed [OUT_W-1:0] steering;
  } lfsl_out_t;

  // Remembered side of the line
  typedef enum logic [1:0] {
    SIDE_NONE = 2'b00,
    SIDE_POS  = 2'b01,
    SIDE_NEG  = 2'b11
  } side_e;

  // Control word fields
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_EMIT
  } seq_op_e;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_CURVE,
    DP_SD2,
    DP_MIX
  } dp_op_e;

  typedef enum logic [2:0] {
    MA_EXCESS,
    MA_CURVE,
    MA_ERR,
    MA_M1,
    MA_M2
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_SLOW_GAIN,
    MB_CURVE_GAIN,
    MB_STEER_GAIN,
    MB_STEER_CURVE_GAIN,
    MB_SD2_HI,
    MB_SD2_LO
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_SHL,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ST,
    RES_PL
  } res_op_e;

  typedef struct packed {
    seq_op_e seq;
    dp_op_e  dp;
    logic    mul_en;
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    acc_op_e acc;
    res_op_e res;
  } ucode_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_FIRST = 4'd1;

  localparam ucode_t UCODE_NOP = '{SEQ_NEXT, DP_NONE, 1'b0, MA_EXCESS, MB_SLOW_GAIN,
                                   ACC_HOLD, RES_NONE};

  // Microprogram: one control word per step
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = UCODE_NOP;
    case (step)
      4'd0: begin
        w.seq = SEQ_WAIT_IN;
      end
      4'd1: begin
        w.dp = DP_CURVE;
      end
      4'd2: begin
        w.mul_en = 1'b1; w.mul_a = MA_EXCESS; w.mul_b = MB_SLOW_GAIN;
      end
      4'd3: begin
        w.dp = DP_SD2;
        w.mul_en = 1'b1; w.mul_a = MA_CURVE; w.mul_b = MB_CURVE_GAIN;
      end
      4'd4: begin
        w.dp = DP_MIX;
        w.mul_en = 1'b1; w.mul_a = MA_ERR; w.mul_b = MB_STEER_GAIN;
      end
      4'd5: begin
        w.acc = ACC_LOAD;
        w.mul_en = 1'b1; w.mul_a = MA_CURVE; w.mul_b = MB_STEER_CURVE_GAIN;
      end
      4'd6: begin
        w.acc = ACC_ADD;
        w.mul_en = 1'b1; w.mul_a = MA_M1; w.mul_b = MB_SD2_HI;
      end
      4'd7: begin
        w.res = RES_ST; w.acc = ACC_LOAD_SHL;
        w.mul_en = 1'b1; w.mul_a = MA_M1; w.mul_b = MB_SD2_LO;
      end
      4'd8: begin
        w.acc = ACC_ADD;
        w.mul_en = 1'b1; w.mul_a = MA_M2; w.mul_b = MB_SD2_HI;
      end
      4'd9: begin
        w.res = RES_PL; w.acc = ACC_LOAD_SHL;
        w.mul_en = 1'b1; w.mul_a = MA_M2; w.mul_b = MB_SD2_LO;
      end
      4'd10: begin
        w.acc = ACC_ADD;
      end
      4'd11: begin
        w.seq = SEQ_EMIT;
      end
      default: begin
        // unused addresses fall back to the idle word
        w.seq = SEQ_WAIT_IN;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/line_follower_steering_law.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_steering_law
// Steering law of a line follower: motor powers and steering from one
// line-position sample, run by a small microprogram over one multiplier.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one position
//   beat with its line-seen and restart flags. Output channel (out_valid_o /
//   out_stall_i / out_data_o) returns one beat of left power, right power and
//   steering for every input beat, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes one register per beat; ready is always high. Write only while idle.
//   The result is registered at the last step; a new input beat is taken only
//   once the sequencer is back at idle. A twelve-step microprogram drives a
//   single shared multiplier through eight products, one per step.
//   Reset clears the remembered side and loads the register defaults.
//   When the receiver stalls, the result beat holds in the output register; a
//   following item runs up to its last step and waits there for the slot.
// ----------------------------------------------------------------------------
module line_follower_steering_law
  import lfsl_pkg::*;
#(
  parameter int FracBits = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lfsl_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lfsl_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW   = ((FracBits + 8 > 25) ? FracBits + 8 : 25) + 1;
  localparam int BW   = (FracBits + 1 > 13) ? FracBits + 1 : 13;
  localparam int PW   = AW + BW + 1;
  localparam int SW   = 2 * FracBits + 1;
  localparam int XW   = FracBits + 1;
  localparam int ACCW = AW + 2 * FracBits + 2;
  localparam int DW   = CURVE_W + 1;

  localparam logic signed [DW-1:0] ONE_D  = DW'(1) << FracBits;
  localparam logic [XW-1:0]        ONE_X  = XW'(1) << FracBits;
  localparam logic [PW-1:0]        ONE_SQ = PW'(1) << (2 * FracBits);

  // Truncate toward zero after a right shift, then saturate to the result width
  function automatic logic signed [OUT_W-1:0] trunc_sat(
    input logic signed [ACCW-1:0] v,
    input int                     shift
  );
    logic signed [ACCW-1:0] bias;
    logic signed [ACCW-1:0] q;
    logic signed [OUT_W-1:0] r;
    bias = v[ACCW-1] ? $signed((ACCW'(1) << shift) - ACCW'(1)) : '0;
    q = (v + bias) >>> shift;
    if (q > ACCW'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (q < ACCW'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [6:0]  base_q;
  logic [7:0]  curve_gain_q;
  logic [12:0] curve_start_q;
  logic [12:0] slow_gain_q;
  logic [7:0]  steer_gain_q;
  logic [7:0]  steer_curve_gain_q;
  logic [14:0] lost_q;

  // Sequencer and state
  step_t  step_q, step_d;
  side_e  side_q, side_d;
  ucode_t uc;
  logic   in_acc;
  logic   emit_go;
  logic   out_valid_q;

  // Datapath registers
  logic signed [POS_W-1:0]   err_q, err_d;
  logic signed [CURVE_W-1:0] curve_q, curve_d;
  logic [XW-1:0]             excess_q, excess_d;
  logic [SW-1:0]             sd2_q, sd2_d;
  logic signed [AW-1:0]      m1_q, m1_d, m2_q, m2_d;
  logic signed [PW-1:0]      prod_q;
  logic signed [ACCW-1:0]    acc_q, acc_d;
  logic signed [OUT_W-1:0]   st_q, pl_q;
  lfsl_out_t                 out_q;

  // Combinational helpers
  side_e                     side_eff;
  logic signed [POS_W-1:0]   lost_pos;
  logic signed [POS_W-1:0]   err_lost;
  logic signed [DW-1:0]      err_x, cs_x, abs_err, diff, neg_diff;
  logic [PW-1:0]             prod_u, sd2_diff;
  logic signed [AW-1:0]      base_one, prod_lo;
  logic signed [AW-1:0]      mul_a;
  logic [BW-1:0]             mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [ACCW-1:0]    prod_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (step_q != STEP_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Fetch the control word and advance the step counter
  always_comb begin
    uc      = ucode_rom(step_q);
    emit_go = (uc.seq == SEQ_EMIT) && (!out_valid_q || !out_stall_i);
    case (uc.seq)
      SEQ_WAIT_IN: step_d = in_acc ? STEP_FIRST : STEP_IDLE;
      SEQ_EMIT:    step_d = emit_go ? STEP_IDLE : step_q;
      default:     step_d = step_q + 4'd1;
    endcase
  end

  // Form the error from the sample or from the remembered side
  always_comb begin
    side_eff = in_data_i.restart ? SIDE_NONE : side_q;
    lost_pos = $signed({1'b0, lost_q});
    case (side_eff)
      SIDE_POS: err_lost = lost_pos;
      SIDE_NEG: err_lost = -lost_pos;
      default:  err_lost = '0;
    endcase
    if (in_data_i.position_valid) begin
      err_d = in_data_i.position;
      if (in_data_i.position > 0) begin
        side_d = SIDE_POS;
      end else if (in_data_i.position < 0) begin
        side_d = SIDE_NEG;
      end else begin
        side_d = SIDE_NONE;
      end
    end else begin
      err_d  = err_lost;
      side_d = side_eff;
    end
  end

  // Curve term and clamped excess past the dead band
  always_comb begin
    err_x    = DW'(err_q);
    cs_x     = $signed(DW'(curve_start_q));
    abs_err  = err_q[POS_W-1] ? -err_x : err_x;
    diff     = abs_err - cs_x;
    neg_diff = -diff;
    if (diff > 0) begin
      curve_d = err_q[POS_W-1] ? neg_diff[CURVE_W-1:0] : diff[CURVE_W-1:0];
    end else begin
      curve_d = '0;
    end
    if (diff <= 0) begin
      excess_d = '0;
    end else if (diff >= ONE_D) begin
      excess_d = ONE_X;
    end else begin
      excess_d = diff[XW-1:0];
    end
  end

  // Slowdown factor, floored at zero
  always_comb begin
    prod_u   = $unsigned(prod_q);
    sd2_diff = ONE_SQ - prod_u;
    sd2_d    = (prod_u >= ONE_SQ) ? '0 : sd2_diff[SW-1:0];
  end

  // Motor mix around the base power
  always_comb begin
    base_one = $signed(AW'(base_q) << FracBits);
    prod_lo  = $signed(prod_q[AW-1:0]);
    m1_d     = base_one + prod_lo;
    m2_d     = base_one - prod_lo;
  end

  // Shared multiplier operand select
  always_comb begin
    case (uc.mul_a)
      MA_EXCESS: mul_a = $signed(AW'(excess_q));
      MA_CURVE:  mul_a = AW'(curve_q);
      MA_ERR:    mul_a = AW'(err_q);
      MA_M1:     mul_a = m1_q;
      MA_M2:     mul_a = m2_q;
      default:   mul_a = '0;
    endcase
    case (uc.mul_b)
      MB_SLOW_GAIN:        mul_b = BW'(slow_gain_q);
      MB_CURVE_GAIN:       mul_b = BW'(curve_gain_q);
      MB_STEER_GAIN:       mul_b = BW'(steer_gain_q);
      MB_STEER_CURVE_GAIN: mul_b = BW'(steer_curve_gain_q);
      MB_SD2_HI:           mul_b = BW'(sd2_q[SW-1:FracBits]);
      MB_SD2_LO:           mul_b = BW'(sd2_q[FracBits-1:0]);
      default:             mul_b = '0;
    endcase
    mul_p = mul_a * $signed({1'b0, mul_b});
  end

  // Accumulator update
  always_comb begin
    prod_ext = ACCW'(prod_q);
    case (uc.acc)
      ACC_LOAD:     acc_d = prod_ext;
      ACC_LOAD_SHL: acc_d = prod_ext <<< FracBits;
      ACC_ADD:      acc_d = acc_q + prod_ext;
      default:      acc_d = acc_q;
    endcase
  end

  // Control state: step counter, side, output valid, configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q             <= STEP_IDLE;
      side_q             <= SIDE_NONE;
      out_valid_q        <= 1'b0;
      base_q             <= RST_BASE_SPEED;
      curve_gain_q       <= RST_CURVE_GAIN;
      curve_start_q      <= RST_CURVE_START;
      slow_gain_q        <= RST_SLOWDOWN_GAIN;
      steer_gain_q       <= RST_STEER_GAIN;
      steer_curve_gain_q <= RST_STEER_CURVE_GAIN;
      lost_q             <= RST_LOST_LINE_ERROR;
    end else begin
      step_q <= step_d;
      if (in_acc) begin
        side_q <= side_d;
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BASE_SPEED:       base_q             <= cfg_data_i[6:0];
          CFG_CURVE_GAIN:       curve_gain_q       <= cfg_data_i[7:0];
          CFG_CURVE_START:      curve_start_q      <= cfg_data_i[12:0];
          CFG_SLOWDOWN_GAIN:    slow_gain_q        <= cfg_data_i[12:0];
          CFG_STEER_GAIN:       steer_gain_q       <= cfg_data_i[7:0];
          CFG_STEER_CURVE_GAIN: steer_curve_gain_q <= cfg_data_i[7:0];
          CFG_LOST_LINE_ERROR:  lost_q             <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, loaded as the control word says
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q <= err_d;
    end
    if (uc.dp == DP_CURVE) begin
      curve_q  <= curve_d;
      excess_q <= excess_d;
    end
    if (uc.dp == DP_SD2) begin
      sd2_q <= sd2_d;
    end
    if (uc.dp == DP_MIX) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
    if (uc.mul_en) begin
      prod_q <= mul_p;
    end
    acc_q <= acc_d;
    if (uc.res == RES_ST) begin
      st_q <= trunc_sat(acc_q, FracBits);
    end
    if (uc.res == RES_PL) begin
      pl_q <= trunc_sat(acc_q, 3 * FracBits);
    end
    if (emit_go) begin
      out_q.left_power  <= pl_q;
      out_q.right_power <= trunc_sat(acc_q, 3 * FracBits);
      out_q.steering    <= st_q;
    end
  end

endmodule

@@ hw/rtl/lfsl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsl_checker
// Port-level checks on the steering law block, bound to its top level.
// ----------------------------------------------------------------------------
module lfsl_checker
  import lfsl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input lfsl_in_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input lfsl_out_t             out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Busy straight after an input beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item in flight");

  // Still busy late in the program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##10 in_stall_o)
    else $error("sequencer left its program early");

  // A new result appears only as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised outside the last step");

endmodule

bind line_follower_steering_law lfsl_checker u_lfsl_checker (.*);

@@ tb/sv/line_follower_steering_law_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_steering_law_test
// Self-checking bench for the steering law. A queue-fed driver offers position
// beats with random gaps, and a monitor takes result beats under random stall.
// Each result is compared field by field with an in-bench prediction. The run
// covers a directed set, then several register settings with random beats.
// ----------------------------------------------------------------------------
module line_follower_steering_law_test;
  import lfsl_pkg::*;

  localparam int FRAC_BITS       = 12;
  localparam int STALL_LIMIT     = 3000;
  localparam int LONG_HOLD       = 300;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES      = 8;
  localparam int DRAIN_CYCLES    = 30;
  localparam int MAX_PRINTED     = 100;
  // index beyond the register file, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // Clock, reset and block ports
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  lfsl_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  lfsl_out_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Register copy and remembered side of the prediction
  logic [6:0]  base_q   = RST_BASE_SPEED;
  logic [7:0]  cgain_q  = RST_CURVE_GAIN;
  logic [12:0] cstart_q = RST_CURVE_START;
  logic [12:0] slow_q   = RST_SLOWDOWN_GAIN;
  logic [7:0]  sgain_q  = RST_STEER_GAIN;
  logic [7:0]  scgain_q = RST_STEER_CURVE_GAIN;
  logic [14:0] lost_q   = RST_LOST_LINE_ERROR;
  side_e       side_q   = SIDE_NONE;

  // Stimulus and expectation stores
  lfsl_in_t  position_q[$];
  lfsl_out_t power_exp_q[$];
  lfsl_in_t  taken_beat;
  int        pushed_cnt     = 0;
  int        result_cnt     = 0;
  int        fail_count     = 0;
  bit        in_beat_taken  = 1'b0;
  bit        out_beat_taken = 1'b0;
  bit        in_gaps_on     = 1'b1;
  bit        out_gaps_on    = 1'b1;
  bit        long_hold_req  = 1'b0;
  int        in_gap         = 0;
  int        stall_left     = 0;
  int        hold_left      = 0;
  int        idle_cycles    = 0;

  line_follower_steering_law #(
    .FracBits(FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Saturate to the 12-bit result range
  function automatic logic signed [OUT_W-1:0] clip_power(input longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // Work out powers and steering for one position beat, advancing the side
  function automatic lfsl_out_t predict_steering(input lfsl_in_t s);
    longint    one, err, cs, curve, excess, sd2, m1, m2;
    lfsl_out_t res;
    one = longint'(1) << FRAC_BITS;
    if (s.restart) side_q = SIDE_NONE;
    if (!s.position_valid) begin
      case (side_q)
        SIDE_POS: err = longint'(lost_q);
        SIDE_NEG: err = -longint'(lost_q);
        default:  err = 0;
      endcase
    end else begin
      err = longint'($signed(s.position));
      if (err > 0) side_q = SIDE_POS;
      else if (err < 0) side_q = SIDE_NEG;
      else side_q = SIDE_NONE;
    end
    cs = longint'(cstart_q);
    if (err > cs) curve = err - cs;
    else if (err < -cs) curve = err + cs;
    else curve = 0;
    excess = (err < 0 ? -err : err) - cs;
    if (excess > one) excess = one;
    if (excess < 0) excess = 0;
    sd2 = one * one - excess * longint'(slow_q);
    if (sd2 < 0) sd2 = 0;
    m1 = longint'(base_q) * one + curve * longint'(cgain_q);
    m2 = longint'(base_q) * one - curve * longint'(cgain_q);
    res.left_power  = clip_power((m1 * sd2) / (longint'(1) << (3 * FRAC_BITS)));
    res.right_power = clip_power((m2 * sd2) / (longint'(1) << (3 * FRAC_BITS)));
    res.steering    = clip_power((err * longint'(sgain_q) + curve * longint'(scgain_q))
                                 / one);
    return res;
  endfunction

  // Random position beat, weighted towards the dead band and slowdown edges
  function automatic lfsl_in_t random_position();
    int       cs, v, pick;
    lfsl_in_t s;
    cs   = int'(cstart_q);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: v = $urandom_range(0, 65535);
      3, 4:    v = cs + int'($urandom_range(0, 40)) - 20;
      5, 6:    v = cs + 4096 + int'($urandom_range(0, 40)) - 20;
      7:       v = int'($urandom_range(0, 600)) - 300;
      8: begin
        case ($urandom_range(0, 4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      default: v = cs + int'($urandom_range(0, 4096));
    endcase
    if (pick >= 3 && pick != 8 && $urandom_range(0, 1) == 1) v = -v;
    s.position       = v[15:0];
    s.position_valid = ($urandom_range(0, 99) >= 15);
    s.restart        = ($urandom_range(0, 19) == 0);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic queue_position(input logic signed [POS_W-1:0] pos, input logic seen,
                                input logic rst_side);
    lfsl_in_t s;
    s.position       = pos;
    s.position_valid = seen;
    s.restart        = rst_side;
    position_q.push_back(s);
    pushed_cnt++;
  endtask

  // Write one register and mirror it into the prediction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BASE_SPEED:       base_q   = data[6:0];
      CFG_CURVE_GAIN:       cgain_q  = data[7:0];
      CFG_CURVE_START:      cstart_q = data[12:0];
      CFG_SLOWDOWN_GAIN:    slow_q   = data[12:0];
      CFG_STEER_GAIN:       sgain_q  = data[7:0];
      CFG_STEER_CURVE_GAIN: scgain_q = data[7:0];
      CFG_LOST_LINE_ERROR:  lost_q   = data[14:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Load one register setting per phase, extremes first
  task automatic program_setting(input int ph);
    logic [CFG_DATA_W-1:0] val [8];
    case (ph)
      1: begin
        foreach (val[i]) val[i] = '0;
      end
      2: begin
        val[CFG_BASE_SPEED]       = 15'd100;
        val[CFG_CURVE_GAIN]       = 15'd255;
        val[CFG_CURVE_START]      = 15'd8191;
        val[CFG_SLOWDOWN_GAIN]    = 15'd4096;
        val[CFG_STEER_GAIN]       = 15'd255;
        val[CFG_STEER_CURVE_GAIN] = 15'd255;
        val[CFG_LOST_LINE_ERROR]  = 15'd32767;
      end
      3: begin
        // out-of-range values, masked to each register's width
        foreach (val[i]) val[i] = 15'h7FFF;
      end
      4: begin
        val[CFG_BASE_SPEED]       = 15'd100;
        val[CFG_CURVE_GAIN]       = 15'($urandom_range(0, 255));
        val[CFG_CURVE_START]      = 15'd0;
        val[CFG_SLOWDOWN_GAIN]    = 15'd4096;
        val[CFG_STEER_GAIN]       = 15'd255;
        val[CFG_STEER_CURVE_GAIN] = 15'd0;
        val[CFG_LOST_LINE_ERROR]  = 15'd0;
      end
      default: begin
        val[CFG_BASE_SPEED]       = 15'($urandom_range(0, 100));
        val[CFG_CURVE_GAIN]       = 15'($urandom_range(0, 255));
        val[CFG_CURVE_START]      = 15'($urandom_range(0, 8191));
        val[CFG_SLOWDOWN_GAIN]    = 15'($urandom_range(0, 4096));
        val[CFG_STEER_GAIN]       = 15'($urandom_range(0, 255));
        val[CFG_STEER_CURVE_GAIN] = 15'($urandom_range(0, 255));
        val[CFG_LOST_LINE_ERROR]  = 15'($urandom_range(0, 32767));
      end
    endcase
    write_reg(CFG_BASE_SPEED,       val[CFG_BASE_SPEED]);
    write_reg(CFG_CURVE_GAIN,       val[CFG_CURVE_GAIN]);
    write_reg(CFG_CURVE_START,      val[CFG_CURVE_START]);
    write_reg(CFG_SLOWDOWN_GAIN,    val[CFG_SLOWDOWN_GAIN]);
    write_reg(CFG_STEER_GAIN,       val[CFG_STEER_GAIN]);
    write_reg(CFG_STEER_CURVE_GAIN, val[CFG_STEER_CURVE_GAIN]);
    write_reg(CFG_LOST_LINE_ERROR,  val[CFG_LOST_LINE_ERROR]);
    if (ph == 3) write_reg(CFG_UNUSED_IDX, 15'h2A5A);
  endtask

  // Hold until every queued beat has produced its result
  task automatic wait_idle();
    while (result_cnt < pushed_cnt) @(negedge clk_i);
  endtask

  // Note an accepted input beat; the driver predicts it at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      taken_beat    = in_data_i;
      in_beat_taken = 1'b1;
    end
  end

  // Input driver: predict the taken beat, then offer the next after a gap
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_valid_i;
    if (in_beat_taken) begin
      in_beat_taken = 1'b0;
      power_exp_q.push_back(predict_steering(taken_beat));
      nxt_valid = 1'b0;
      if ($urandom_range(0, 63) == 0) in_gaps_on = !in_gaps_on;
      in_gap = in_gaps_on ? $urandom_range(0, 15) : 0;
    end
    if (!nxt_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (position_q.size() != 0) begin
        in_data_i <= position_q.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
  end

  // Result monitor: compare each taken beat with the oldest expectation
  always @(posedge clk_i) begin
    lfsl_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_beat_taken = 1'b1;
      result_cnt++;
      if (power_exp_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (%0d %0d %0d)",
                                  out_data_o.left_power, out_data_o.right_power,
                                  out_data_o.steering));
      end else begin
        want = power_exp_q.pop_front();
        if (out_data_o.left_power !== want.left_power)
          report_mismatch($sformatf("left_power %0d, expected %0d",
                                    out_data_o.left_power, want.left_power));
        if (out_data_o.right_power !== want.right_power)
          report_mismatch($sformatf("right_power %0d, expected %0d",
                                    out_data_o.right_power, want.right_power));
        if (out_data_o.steering !== want.steering)
          report_mismatch($sformatf("steering %0d, expected %0d",
                                    out_data_o.steering, want.steering));
      end
    end
  end

  // Receiver: stall per beat, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
    end
    if (out_beat_taken) begin
      out_beat_taken = 1'b0;
      if ($urandom_range(0, 63) == 0) out_gaps_on = !out_gaps_on;
      stall_left = out_gaps_on ? $urandom_range(0, 15) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sequence: reset, directed beats, then random phases under new settings
  initial begin
    int cs;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    cs = int'(RST_CURVE_START);
    // valid zero, then lost line with no side known
    queue_position(16'sd0, 1'b1, 1'b0);
    queue_position(16'sd0, 1'b0, 1'b0);
    // extremes, each followed by a lost line on that side
    queue_position(16'sh7FFF, 1'b1, 1'b0);
    queue_position(16'sd0, 1'b0, 1'b0);
    queue_position(16'sh8000, 1'b1, 1'b0);
    queue_position(16'sh1234, 1'b0, 1'b0);
    // restart with lost line clears the side first
    queue_position(16'sd0, 1'b0, 1'b1);
    queue_position(16'sd0, 1'b0, 1'b0);
    queue_position(16'sd100, 1'b1, 1'b1);
    // dead band and slowdown edges
    queue_position(16'(cs), 1'b1, 1'b0);
    queue_position(16'(cs + 1), 1'b1, 1'b0);
    queue_position(16'(-cs), 1'b1, 1'b0);
    queue_position(16'(-cs - 1), 1'b1, 1'b0);
    queue_position(16'(cs + 4096), 1'b1, 1'b0);
    queue_position(16'(-cs - 4096), 1'b1, 1'b0);
    queue_position(16'(cs + 4097), 1'b1, 1'b0);
    queue_position(16'(-cs - 3000), 1'b1, 1'b0);
    // valid zero forgets the side
    queue_position(-16'sd1, 1'b1, 1'b0);
    queue_position(16'sd0, 1'b1, 1'b0);
    queue_position(16'sh5A5A, 1'b0, 1'b0);
    queue_position(16'sd1, 1'b1, 1'b0);
    queue_position(-16'sd7, 1'b0, 1'b0);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) program_setting(ph);
      @(posedge clk_i);
      repeat (ITEMS_PER_PHASE) position_q.push_back(random_position());
      pushed_cnt += ITEMS_PER_PHASE;
      // let the block fill up behind a held-off receiver
      if (ph == 2 || ph == 5) long_hold_req = 1'b1;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (power_exp_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", power_exp_q.size()));
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ line_follower_steering_law.f @@
hw/rtl/lfsl_pkg.sv
hw/rtl/line_follower_steering_law.sv
hw/rtl/lfsl_checker.sv
tb/sv/line_follower_steering_law_test.sv
